// ----- rtl/core/dsnl_pkg.sv -----
`timescale 1ns / 1ps
package dsnl_pkg;

	localparam int NODES_DEF = 64;
	localparam int SLOT_W    = 6;
	localparam int KEY_W     = 16;
	localparam int LINK_W    = 7;
	localparam logic [LINK_W-1:0] NULL_LINK = 7'd64;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_WALK   = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOT_LIVE = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	typedef struct packed {
		logic [1:0]        operation;
		logic [KEY_W-1:0]  key;
		logic [SLOT_W-1:0] node;
	} in_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [KEY_W-1:0]  depth;
		logic [1:0]        status;
		logic              last;
	} out_t;

	// a command handed from front to back; op code 3 never gets here
	typedef struct packed {
		logic [1:0]        op;
		logic [KEY_W-1:0]  key;
		logic [SLOT_W-1:0] node;
	} cmd_t;

endpackage

// ----- rtl/core/depth_sorted_node_list.sv -----
`timescale 1ns / 1ps
// Channel  Ports                   Moves
// input    push, full, item        one transaction: operation, key, node
// result   empty, pop, result      one transaction: slot, depth, status, last
//
// Insert: compares keys from the head on, one node at a time, until it meets a key
// not above its own or the list end, then writes the node. Walk: emits live nodes in order.
// Delete unlinks in S_DLINK, refusals answer from S_REPLY; op code 3 is dropped in the front end.
// The single read port of the key and link memories puts a read before each compare or emit.
// Reset (arst_n) empties the list and the queues; no clearing pass is needed.
// A full result queue stalls the back end; the input queue keeps taking up to two items.
module depth_sorted_node_list #(
	parameter int NODES = dsnl_pkg::NODES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  dsnl_pkg::in_t  item,
	output logic           empty,
	input  logic           pop,
	output dsnl_pkg::out_t result
);

	logic           cmd_valid, cmd_take, res_full, res_wr;
	dsnl_pkg::cmd_t cmd;
	dsnl_pkg::out_t res_data;

	dsnl_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
	);

	dsnl_back #(.NODES(NODES)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd(cmd),
		.cmd_take(cmd_take), .res_full(res_full), .res_wr(res_wr), .res_data(res_data)
	);

	dsnl_resq u_resq (
		.clk(clk), .arst_n(arst_n), .wr(res_wr), .wdata(res_data), .full(res_full),
		.empty(empty), .pop(pop), .result(result)
	);

endmodule

// ----- rtl/core/dsnl_front.sv -----
`timescale 1ns / 1ps
module dsnl_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  dsnl_pkg::in_t    item,
	output logic             cmd_valid,
	output dsnl_pkg::cmd_t   cmd,
	input  logic             cmd_take
);

	dsnl_pkg::cmd_t ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       acc, keep;

	assign full      = (cnt_q == 2'd2);
	assign acc       = push && !full;
	// unused op code is swallowed here: no command, no result
	assign keep      = acc && (item.operation == dsnl_pkg::OP_INSERT ||
		item.operation == dsnl_pkg::OP_DELETE || item.operation == dsnl_pkg::OP_WALK);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (keep) begin
			ent_q[wp_q] <= '{op: item.operation, key: item.key, node: item.node};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (keep) wp_q <= ~wp_q;
			if (cmd_take) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, keep} - {1'b0, cmd_take};
		end
	end

endmodule

// ----- rtl/core/dsnl_resq.sv -----
`timescale 1ns / 1ps
module dsnl_resq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  dsnl_pkg::out_t wdata,
	output logic           full,
	output logic           empty,
	input  logic           pop,
	output dsnl_pkg::out_t result
);

	dsnl_pkg::out_t ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       rd;

	assign full   = (cnt_q == 2'd2);
	assign empty  = (cnt_q == 2'd0);
	assign rd     = pop && !empty;
	assign result = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			ent_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

endmodule

// ----- rtl/core/dsnl_back.sv -----
`timescale 1ns / 1ps
module dsnl_back #(
	parameter int NODES = dsnl_pkg::NODES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  dsnl_pkg::cmd_t cmd,
	output logic           cmd_take,
	input  logic           res_full,
	output logic           res_wr,
	output dsnl_pkg::out_t res_data
);

	localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int LW = dsnl_pkg::LINK_W;
	localparam int KW = dsnl_pkg::KEY_W;
	localparam int SW = dsnl_pkg::SLOT_W;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_ISCAN = 4'd1;
	localparam logic [3:0] S_ICMP  = 4'd2;
	localparam logic [3:0] S_IW1   = 4'd3;
	localparam logic [3:0] S_IW2   = 4'd4;
	localparam logic [3:0] S_DLINK = 4'd5;
	localparam logic [3:0] S_WREAD = 4'd6;
	localparam logic [3:0] S_WEMIT = 4'd7;
	localparam logic [3:0] S_REPLY = 4'd8;

	logic [KW-1:0] key_mem  [NODES];
	logic [LW-1:0] next_mem [NODES];
	logic [LW-1:0] prev_mem [NODES];
	logic [AW-1:0] fs_mem   [NODES];

	logic [NODES-1:0] fs_vld_q, live_q;
	logic [LW-1:0]    head_q, cnt_q;
	logic [3:0]       st_q;
	logic [LW-1:0]    cur_q, before_q, guard_q, n_q;
	logic [AW-1:0]    slot_q;
	logic [KW-1:0]    key_q;
	dsnl_pkg::out_t   res_q;

	logic [KW-1:0] key_rd_q;
	logic [LW-1:0] next_rd_q, prev_rd_q;
	logic [AW-1:0] fs_rd_q;
	logic          fs_hit_q;

	logic [AW-1:0] rd_addr, top_idx, fs_slot, node_idx;
	logic          k_we, n_we, p_we;
	logic [AW-1:0] k_wa, n_wa, p_wa;
	logic [LW-1:0] n_wd, p_wd;
	logic          walk_fin, node_bad;

	assign top_idx  = cnt_q[AW-1:0];
	assign node_idx = cmd.node[AW-1:0];
	assign fs_slot  = fs_hit_q ? fs_rd_q : top_idx;
	assign walk_fin = next_rd_q[LW-1] || (n_q == LW'(NODES - 2));
	assign rd_addr  = (st_q == S_IDLE) ? node_idx : cur_q[AW-1:0];
	assign node_bad = ({1'b0, cmd.node} >= LW'(NODES)) || !live_q[node_idx] ||
		(cnt_q == '0);

	always_ff @(posedge clk) begin
		key_rd_q  <= key_mem[rd_addr];
		next_rd_q <= next_mem[rd_addr];
		prev_rd_q <= prev_mem[rd_addr];
		fs_rd_q   <= fs_mem[top_idx];
		fs_hit_q  <= fs_vld_q[top_idx];
		if (k_we) key_mem[k_wa] <= key_q;
		if (n_we) next_mem[n_wa] <= n_wd;
		if (p_we) prev_mem[p_wa] <= p_wd;
		if (st_q == S_DLINK && !res_full) fs_mem[AW'(cnt_q - 1'b1)] <= slot_q;
	end

	always_comb begin
		k_we = 1'b0; k_wa = slot_q;
		n_we = 1'b0; n_wa = slot_q; n_wd = cur_q;
		p_we = 1'b0; p_wa = slot_q; p_wd = before_q;
		res_wr   = 1'b0;
		res_data = res_q;
		cmd_take = (st_q == S_IDLE) && cmd_valid;
		case (st_q)
			S_IW1: begin
				k_we = 1'b1;
				n_we = 1'b1;
				p_we = 1'b1;
			end
			S_IW2: begin
				n_wa = before_q[AW-1:0]; n_wd = {1'b0, SW'(slot_q)};
				p_wa = cur_q[AW-1:0];    p_wd = {1'b0, SW'(slot_q)};
				n_we = !res_full && !before_q[LW-1];
				p_we = !res_full && !cur_q[LW-1];
				res_wr   = !res_full;
				res_data = '{slot: SW'(slot_q), depth: key_q,
					status: dsnl_pkg::ST_OK, last: 1'b1};
			end
			S_DLINK: begin
				n_wa = prev_rd_q[AW-1:0]; n_wd = next_rd_q;
				p_wa = next_rd_q[AW-1:0]; p_wd = prev_rd_q;
				n_we = !res_full && !prev_rd_q[LW-1];
				p_we = !res_full && !next_rd_q[LW-1];
				res_wr   = !res_full;
				res_data = '{slot: SW'(slot_q), depth: '0,
					status: dsnl_pkg::ST_OK, last: 1'b1};
			end
			S_WEMIT: begin
				res_wr   = !res_full;
				res_data = '{slot: SW'(cur_q[AW-1:0]), depth: key_rd_q,
					status: dsnl_pkg::ST_OK, last: walk_fin};
			end
			S_REPLY: begin
				res_wr = !res_full;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				key_q    <= cmd.key;
				slot_q   <= node_idx;
				before_q <= dsnl_pkg::NULL_LINK;
				guard_q  <= '0;
				n_q      <= '0;
				cur_q    <= (cmd.op == dsnl_pkg::OP_DELETE) ? {1'b0, SW'(node_idx)} : head_q;
				case (cmd.op)
					dsnl_pkg::OP_INSERT: res_q <= '{slot: '0, depth: cmd.key,
						status: dsnl_pkg::ST_FULL, last: 1'b1};
					dsnl_pkg::OP_DELETE: res_q <= '{slot: cmd.node, depth: '0,
						status: dsnl_pkg::ST_NOT_LIVE, last: 1'b1};
					default: res_q <= '{slot: '0, depth: '0,
						status: dsnl_pkg::ST_EMPTY, last: 1'b1};
				endcase
			end
			S_ISCAN: slot_q <= fs_slot;
			S_ICMP: begin
				if (key_rd_q > key_q) begin
					before_q <= cur_q;
					cur_q    <= next_rd_q;
					guard_q  <= guard_q + 1'b1;
				end
			end
			S_WEMIT: begin
				if (!res_full) begin
					n_q   <= n_q + 1'b1;
					cur_q <= next_rd_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			head_q   <= dsnl_pkg::NULL_LINK;
			cnt_q    <= '0;
			live_q   <= '0;
			fs_vld_q <= '0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (cmd_valid) begin
						case (cmd.op)
							dsnl_pkg::OP_INSERT:
								st_q <= (cnt_q >= LW'(NODES - 1)) ? S_REPLY : S_ISCAN;
							dsnl_pkg::OP_DELETE:
								st_q <= node_bad ? S_REPLY : S_DLINK;
							default:
								st_q <= (head_q[LW-1] || cnt_q == '0) ? S_REPLY : S_WREAD;
						endcase
					end
				end
				S_ISCAN:
					st_q <= (cur_q[LW-1] || guard_q == LW'(NODES)) ? S_IW1 : S_ICMP;
				S_ICMP:
					st_q <= (key_rd_q > key_q) ? S_ISCAN : S_IW1;
				S_IW1: begin
					live_q[slot_q] <= 1'b1;
					st_q <= S_IW2;
				end
				S_IW2: begin
					if (!res_full) begin
						if (before_q[LW-1]) head_q <= {1'b0, SW'(slot_q)};
						cnt_q <= cnt_q + 1'b1;
						st_q  <= S_IDLE;
					end
				end
				S_DLINK: begin
					if (!res_full) begin
						if (prev_rd_q[LW-1]) head_q <= next_rd_q;
						live_q[slot_q] <= 1'b0;
						fs_vld_q[AW'(cnt_q - 1'b1)] <= 1'b1;
						cnt_q <= cnt_q - 1'b1;
						st_q  <= S_IDLE;
					end
				end
				S_WREAD: st_q <= S_WEMIT;
				S_WEMIT: begin
					if (!res_full) st_q <= walk_fin ? S_IDLE : S_WREAD;
				end
				S_REPLY: begin
					if (!res_full) st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= LW'(NODES - 1)) else $error("live count beyond pool");
	a_head_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) == head_q[LW-1]) else $error("head and live count disagree");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		res_wr |-> !res_full) else $error("result written into full queue");
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |=> (st_q != S_IDLE)) else $error("command taken but no work started");

endmodule
